/* sv/rbhd_pkg.sv */
// Package for the relay burst/hold driver: shared types, codes and reset values.
// No dependencies; imported by every module of the block.
package rbhd_pkg;

  localparam int unsigned MASK_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_TICKS  = 1'b1;

  // Command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  localparam logic [MASK_W-1:0] SUSTAIN_MASK_RST = 16'hAAAA;
  localparam logic [BYTE_W-1:0] BURST_TICKS_RST  = 8'd50;
  localparam logic [BYTE_W-1:0] LINE_OFF         = 8'hFF;
  localparam logic [IDX_W-1:0]  IDX_LAST         = 3'd7;

  // One tick's work, handed from the state stage to the serializer
  typedef struct packed {
    logic [BYTE_W-1:0] line;     // inverted drive byte to shift out
    logic [BYTE_W-1:0] latched;  // byte latched at the start of this tick
  } tick_rec_t;

  typedef struct packed {
    logic      valid;
    tick_rec_t rec;
  } tick_req_t;

endpackage

/* sv/rbhd_core.sv */
// State stage of the relay burst/hold driver: input register, relay pattern,
// burst counter, rotating hold mask and configuration registers. Uses rbhd_pkg.
module rbhd_core
  import rbhd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [BYTE_W-1:0]    in_relay_pattern,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data,
  output tick_req_t            tick_req,
  input  logic                 tick_ready
);

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_cmd_r;
  logic [BYTE_W-1:0] s1_pat_r;

  logic [MASK_W-1:0] sustain_mask_r;
  logic [BYTE_W-1:0] burst_ticks_r;
  logic [BYTE_W-1:0] stored_pattern_r;
  logic [MASK_W-1:0] hold_mask_r;
  logic [BYTE_W-1:0] burst_left_r;
  logic [BYTE_W-1:0] preloaded_r;

  logic              adv;
  logic              in_xfer;
  logic [BYTE_W-1:0] drive;
  logic [BYTE_W-1:0] line_nxt;

  assign adv      = s1_valid_r && ((s1_cmd_r == CMD_SET) || tick_ready);
  assign in_stall = s1_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    if (burst_left_r == '0) begin
      drive = stored_pattern_r & hold_mask_r[BYTE_W-1:0];
    end else begin
      drive = stored_pattern_r;
    end
    line_nxt = ~drive;
  end

  assign tick_req.valid       = s1_valid_r && (s1_cmd_r == CMD_TICK);
  assign tick_req.rec.line    = line_nxt;
  assign tick_req.rec.latched = preloaded_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r <= in_cmd;
      s1_pat_r <= in_relay_pattern;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sustain_mask_r   <= SUSTAIN_MASK_RST;
      burst_ticks_r    <= BURST_TICKS_RST;
      stored_pattern_r <= '0;
      hold_mask_r      <= SUSTAIN_MASK_RST;
      burst_left_r     <= '0;
      preloaded_r      <= LINE_OFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SUSTAIN_MASK: begin
          sustain_mask_r <= cfg_data;
          hold_mask_r    <= cfg_data;
        end
        CFG_BURST_TICKS: burst_ticks_r <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end else if (adv) begin
      if (s1_cmd_r == CMD_SET) begin
        if (s1_pat_r != stored_pattern_r) begin
          burst_left_r <= burst_ticks_r;
        end
        stored_pattern_r <= s1_pat_r;
      end else begin
        if (burst_left_r != '0) begin
          burst_left_r <= burst_left_r - 1'b1;
        end
        preloaded_r <= line_nxt;
        hold_mask_r <= {hold_mask_r[MASK_W-2:0], hold_mask_r[MASK_W-1]};
      end
    end
  end

endmodule

/* sv/rbhd_shift.sv */
// Serializer of the relay burst/hold driver: emits one drive byte as eight
// serial bits, LSB first, on the result channel. Uses rbhd_pkg.
module rbhd_shift
  import rbhd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  tick_req_t         tick_req,
  output logic              tick_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_serial_bit,
  output logic [IDX_W-1:0]  out_bit_index,
  output logic              out_last_bit,
  output logic [BYTE_W-1:0] out_latched_outputs
);

  logic              active_r, active_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [BYTE_W-1:0] line_r;
  logic [BYTE_W-1:0] latched_r;
  logic              out_xfer;
  logic              is_last;
  logic              load;

  assign is_last    = (idx_r == IDX_LAST);
  assign out_xfer   = active_r && !out_stall;
  assign tick_ready = !active_r || (out_xfer && is_last);
  assign load       = tick_req.valid && tick_ready;

  assign out_valid           = active_r;
  assign out_serial_bit      = line_r[idx_r];
  assign out_bit_index       = idx_r;
  assign out_last_bit        = is_last;
  assign out_latched_outputs = latched_r;

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (load) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end else if (out_xfer) begin
      if (is_last) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      line_r    <= tick_req.rec.line;
      latched_r <= tick_req.rec.latched;
    end
  end

endmodule

/* sv/relay_burst_hold_driver.sv */
// Top level of the relay burst/hold driver: coil economizer for eight
// active-low relays fed through an external serial shift register.
// Depends on rbhd_pkg, rbhd_core and rbhd_shift.
//
// A set command (cmd = 1) stores a relay pattern; a changed pattern reloads
// the burst counter from burst_ticks. A tick (cmd = 0) latches the byte
// preloaded on the previous tick, forms the next drive byte (full pattern
// while the burst counter runs, else the pattern ANDed with the low byte of
// the rotating hold mask) and emits it inverted, LSB first, as eight result
// transfers, one serial bit each. A tick therefore occupies the result port
// until its last bit transfers, and the serializer, which holds one tick at a
// time, sets the sustained tick rate. A set command yields no transfer. The
// input register accepts the next item while the serializer is still
// shifting, and a tick waiting there is handed over in the cycle the
// previous tick's last bit transfers, so back-to-back ticks leave no gap.
// Writing sustain_mask also reloads the hold mask. Configure only when idle.
module relay_burst_hold_driver
  import rbhd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [BYTE_W-1:0]    in_relay_pattern,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_serial_bit,
  output logic [IDX_W-1:0]     out_bit_index,
  output logic                 out_last_bit,
  output logic [BYTE_W-1:0]    out_latched_outputs,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data
);

  tick_req_t tick_req;
  logic      tick_ready;

  // Hold the incoming item, update relay state, form the drive byte
  rbhd_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_relay_pattern (in_relay_pattern),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .tick_req         (tick_req),
    .tick_ready       (tick_ready)
  );

  // Shift the drive byte out, one bit per result transfer
  rbhd_shift u_shift (
    .clk                 (clk),
    .rst_n               (rst_n),
    .tick_req            (tick_req),
    .tick_ready          (tick_ready),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_serial_bit      (out_serial_bit),
    .out_bit_index       (out_bit_index),
    .out_last_bit        (out_last_bit),
    .out_latched_outputs (out_latched_outputs)
  );

endmodule

/* dv/relay_burst_hold_driver_tb.sv */
// Testbench for relay_burst_hold_driver: directed and random ticks and set commands
// checked against a built-in predictor of the burst/hold drive bytes.
// Depends on rbhd_pkg and the relay_burst_hold_driver RTL.
module relay_burst_hold_driver_tb;
  import rbhd_pkg::*;

  // One expected serial-bit transfer
  typedef struct packed {
    logic              serial;
    logic [IDX_W-1:0]  idx;
    logic              last;
    logic [BYTE_W-1:0] latched;
  } drive_bit_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_cmd = CMD_TICK;
  logic [BYTE_W-1:0]    in_relay_pattern = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_serial_bit;
  logic [IDX_W-1:0]     out_bit_index;
  logic                 out_last_bit;
  logic [BYTE_W-1:0]    out_latched_outputs;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SUSTAIN_MASK;
  logic [MASK_W-1:0]    cfg_data = '0;

  relay_burst_hold_driver dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_relay_pattern    (in_relay_pattern),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_serial_bit      (out_serial_bit),
    .out_bit_index       (out_bit_index),
    .out_last_bit        (out_last_bit),
    .out_latched_outputs (out_latched_outputs),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: registers as last written, plus the block's own state
  logic [MASK_W-1:0] sustain_reg  = SUSTAIN_MASK_RST;
  logic [BYTE_W-1:0] burst_reg    = BURST_TICKS_RST;
  logic [BYTE_W-1:0] coil_pattern = '0;
  logic [MASK_W-1:0] rot_mask     = SUSTAIN_MASK_RST;
  logic [BYTE_W-1:0] burst_cnt    = '0;
  logic [BYTE_W-1:0] next_line    = LINE_OFF;

  drive_bit_t pending_bits[$];   // serial bits still owed by the block
  int         mismatches = 0;
  bit         no_idle = 1'b0;    // suppress random idling on both sides
  int         hold_request = 0;  // receiver hold-off length asked by a test
  int         hold_left = 0;

  // Advance the predictor by one accepted item; a tick owes eight bits.
  function automatic void forecast_drive(input logic cmd, input logic [BYTE_W-1:0] pat);
    logic [BYTE_W-1:0] drive;
    logic [BYTE_W-1:0] line;
    drive_bit_t        b;
    if (cmd == CMD_SET) begin
      // Only a real change restarts the full-drive burst
      if (pat != coil_pattern) burst_cnt = burst_reg;
      coil_pattern = pat;
      return;
    end
    drive = coil_pattern;
    if (burst_cnt == '0) drive = drive & rot_mask[BYTE_W-1:0];
    else burst_cnt = burst_cnt - 1'b1;
    line = ~drive;
    for (int k = 0; k < BYTE_W; k++) begin
      b.serial  = line[k];
      b.idx     = IDX_W'(k);
      b.last    = (IDX_W'(k) == IDX_LAST);
      b.latched = next_line;
      pending_bits.push_back(b);
    end
    next_line = line;
    rot_mask = {rot_mask[MASK_W-2:0], rot_mask[MASK_W-1]};
  endfunction

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_request != 0) begin
      hold_left = hold_request - 1;
      hold_request = 0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 32);
    end
  end

  // Check every result transfer against the oldest owed bit.
  always @(posedge clk) begin
    drive_bit_t e;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_bits.size() == 0) begin
        $display("%0t: unexpected transfer, bit_index %0d", $time, out_bit_index);
        mismatches++;
      end else begin
        e = pending_bits.pop_front();
        if (out_serial_bit !== e.serial) begin
          $display("%0t: serial_bit expected %0b got %0b", $time, e.serial, out_serial_bit);
          mismatches++;
        end
        if (out_bit_index !== e.idx) begin
          $display("%0t: bit_index expected %0d got %0d", $time, e.idx, out_bit_index);
          mismatches++;
        end
        if (out_last_bit !== e.last) begin
          $display("%0t: last_bit expected %0b got %0b", $time, e.last, out_last_bit);
          mismatches++;
        end
        if (out_latched_outputs !== e.latched) begin
          $display("%0t: latched_outputs expected %h got %h", $time, e.latched,
                   out_latched_outputs);
          mismatches++;
        end
      end
    end
  end

  // Offer one item after an optional random gap; return once it transfers.
  // Valid stays high afterwards so back-to-back items need no extra edge.
  task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] pat);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 32) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_relay_pattern <= pat;
    do @(posedge clk); while (in_stall !== 1'b0);
    forecast_drive(cmd, pat);
  endtask

  // Drop valid, wait for every owed bit, then let a trailing set command settle.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; only call while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SUSTAIN_MASK) begin
      sustain_reg = val;
      rot_mask    = val;
    end else begin
      burst_reg = val[BYTE_W-1:0];
    end
  endtask

  // Ticks straight out of reset: all relays off, outputs latched off.
  task automatic test_power_up();
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'h00);
    quiesce();
  endtask

  // Short burst, repeat of the same pattern, burst expiry into hold drive.
  task automatic test_burst_refresh();
    write_reg(CFG_BURST_TICKS, 16'd3);
    send_item(CMD_SET, 8'hFF);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_SET, 8'hFF);      // same pattern: counter keeps running down
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'h00);     // burst spent, hold mask gates this one
    send_item(CMD_SET, 8'h00);
    send_item(CMD_TICK, 8'hFF);
    quiesce();
  endtask

  // Zero burst length: a change goes straight to hold drive.
  task automatic test_zero_burst();
    write_reg(CFG_BURST_TICKS, 16'd0);
    send_item(CMD_SET, 8'h5A);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'h00);
    quiesce();
  endtask

  // Mask extremes and the wrap of bit 15 into bit 0, then the longest burst.
  task automatic test_mask_extremes();
    write_reg(CFG_SUSTAIN_MASK, 16'hFFFF);
    send_item(CMD_TICK, 8'h00);
    quiesce();
    write_reg(CFG_SUSTAIN_MASK, 16'h0000);
    send_item(CMD_TICK, 8'h00);
    quiesce();
    write_reg(CFG_SUSTAIN_MASK, 16'h8001);
    send_item(CMD_SET, 8'hA5);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_TICK, 8'h00);
    quiesce();
    write_reg(CFG_BURST_TICKS, 16'd255);
    send_item(CMD_SET, 8'h3C);
    send_item(CMD_TICK, 8'h00);
    quiesce();
  endtask

  // Random traffic in phases, each with its own register settings.
  task automatic test_random_traffic();
    logic [MASK_W-1:0] mask_val;
    logic [BYTE_W-1:0] burst_val;
    logic [BYTE_W-1:0] pat;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          mask_val = 16'hFFFF; burst_val = 8'd0;
        end
        1: begin
          mask_val = 16'h0000; burst_val = 8'd255;
        end
        2: begin
          mask_val = 16'($urandom); burst_val = 8'($urandom_range(1, 6));
        end
        default: begin
          mask_val = 16'($urandom); burst_val = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(CFG_SUSTAIN_MASK, mask_val);
      write_reg(CFG_BURST_TICKS, {8'h00, burst_val});
      no_idle = (ph == 0);   // one long stretch with no idling at all
      for (int i = 0; i < 22; i++) begin
        if ($urandom_range(99) < 25) begin
          // Some sets repeat the stored pattern to leave the burst alone
          pat = ($urandom_range(99) < 30) ? coil_pattern : 8'($urandom);
          send_item(CMD_SET, pat);
        end else begin
          send_item(CMD_TICK, 8'($urandom));
        end
        // Sender pause: hold off until every owed bit has been seen
        if (i == 15 && ph == 2) begin
          in_valid <= 1'b0;
          while (pending_bits.size() != 0) @(posedge clk);
          @(posedge clk);
        end
      end
      no_idle = 1'b0;
      quiesce();
    end
  endtask

  // Long receiver hold-off while ticks keep coming, so the input backs up.
  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_request = 60;
    send_item(CMD_SET, 8'($urandom));
    for (int i = 0; i < 12; i++) send_item(CMD_TICK, 8'($urandom));
    no_idle = 1'b0;
    quiesce();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_power_up();
    test_burst_refresh();
    test_zero_burst();
    test_mask_extremes();
    test_random_traffic();
    test_backpressure();
    quiesce();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
